// ===== sv/lsp_pkg.sv =====
`default_nettype none

package lsp_pkg;

    localparam int WORD_W   = 32;
    localparam int ACTION_W = 3;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic signed [WORD_W-1:0] ERR_WORD = -32'sd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH   = 3'd0,
        ACT_POP    = 3'd1,
        ACT_PEEK   = 3'd2,
        ACT_BOTTOM = 3'd3,
        ACT_TOP    = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_PEEK  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // shift commands broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== sv/lsp_if.sv =====
`default_nettype none

interface lsp_req_if;
    logic                               valid;
    logic                               ready;
    logic [lsp_pkg::ACTION_W-1:0]       action;
    logic signed [lsp_pkg::WORD_W-1:0]  push_value;
    logic [lsp_pkg::POS_W-1:0]          position;

    modport source (output valid, output action, output push_value, output position,
                    input ready);
    modport sink   (input valid, input action, input push_value, input position,
                    output ready);
endinterface

interface lsp_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [lsp_pkg::WORD_W-1:0]  read_value;
    logic [lsp_pkg::STATUS_W-1:0]       status;
    logic [lsp_pkg::COUNT_W-1:0]        entry_count;

    modport source (output valid, output read_value, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input entry_count,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/lifo_stack_with_peek.sv =====
`default_nettype none

// Bounded last-in first-out stack of signed 32-bit words, DEPTH entries deep.
// Requests arrive on i_req (valid/ready): push, pop, peek at a depth, read the
// bottom or read the top. Every request gives exactly one result on o_rsp with
// the word, a status code and the entry count after the request.
// Storage is a row of cells, cell 0 holding the top; push and pop shift the
// whole row by one place.
// Push, pop, top and every error case: result register, then output register;
// a new request is taken every cycle while the output register is free.
// Peek and bottom read the target word over a registered chain that moves it
// one cell per cycle toward the top into the output register (the target lies
// at most DEPTH-1 cells below the top), and no request is taken during the
// chain walk.
// Reset empties the stack and drops any pending result; cell contents are
// not cleared. If the receiver stalls, the result waits in the output
// register and the next request is still taken and worked; the request after
// that waits until the output register frees up.
module lifo_stack_with_peek #(
    parameter int DEPTH = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lsp_req_if.sink     i_req,
    lsp_rsp_if.source   o_rsp
);
    import lsp_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [IW-1:0]          r_tgt, n_tgt;
    logic [IW-1:0]          r_scan, n_scan;
    logic signed [WORD_W-1:0] r_res_value, n_res_value;
    t_status                r_res_status, n_res_status;
    logic                   r_from_chain, n_from_chain;

    logic                   r_out_valid;
    logic signed [WORD_W-1:0] r_out_value;
    logic [STATUS_W-1:0]    r_out_status;
    logic [COUNT_W-1:0]     r_out_count;

    logic                   in_ready;
    logic                   load_out;
    logic                   out_free;
    t_cell_ctl              ctl;

    logic signed [WORD_W-1:0] w_word [DEPTH];
    logic signed [WORD_W-1:0] w_rd   [DEPTH];

    logic                   full;
    logic                   empty;
    logic [CMPW-1:0]        count_w;
    logic [CMPW-1:0]        down_w;
    logic [CMPW-1:0]        last_w;
    logic                   peek_err;

    // ---------------- cell row ----------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [WORD_W-1:0] word_above;
        logic signed [WORD_W-1:0] word_below;
        logic signed [WORD_W-1:0] rd_below;

        if (g == 0) begin : g_top
            assign word_above = i_req.push_value;
        end else begin : g_mid
            assign word_above = w_word[g-1];
        end

        if (g == DEPTH - 1) begin : g_bot
            assign word_below = '0;
            assign rd_below   = '0;
        end else begin : g_up
            assign word_below = w_word[g+1];
            assign rd_below   = w_rd[g+1];
        end

        lsp_cell #(
            .IDX (g),
            .IW  (IW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_word_above (word_above),
            .i_word_below (word_below),
            .i_tgt        (r_tgt),
            .i_rd_below   (rd_below),
            .o_word       (w_word[g]),
            .o_rd         (w_rd[g])
        );
    end

    // ---------------- request decode ----------------
    assign full     = (r_count == CW'(DEPTH));
    assign empty    = (r_count == '0);
    assign count_w  = CMPW'(r_count);
    assign down_w   = (i_req.position <= POS_W'(1)) ? '0 : CMPW'(i_req.position - POS_W'(1));
    assign last_w   = count_w - CMPW'(1);
    assign peek_err = (down_w >= count_w);
    assign out_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tgt        <= n_tgt;
        r_scan       <= n_scan;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_from_chain <= n_from_chain;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_tgt        = r_tgt;
        n_scan       = r_scan;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_from_chain = r_from_chain;
        in_ready     = 1'b0;
        load_out     = 1'b0;
        ctl          = '0;

        case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
            end
            ST_SCAN: begin
                if (r_scan == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_scan = r_scan - IW'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    in_ready = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (in_ready && i_req.valid) begin
            n_state      = ST_DONE;
            n_from_chain = 1'b0;
            n_res_value  = '0;
            n_res_status = STAT_OK;
            case (i_req.action)
                ACT_PUSH: begin
                    if (full) begin
                        n_res_value  = ERR_WORD;
                        n_res_status = STAT_FULL;
                    end else begin
                        ctl.push    = 1'b1;
                        n_count     = r_count + CW'(1);
                        n_res_value = i_req.push_value;
                    end
                end
                ACT_POP: begin
                    if (empty) begin
                        n_res_value  = ERR_WORD;
                        n_res_status = STAT_EMPTY;
                    end else begin
                        ctl.pop     = 1'b1;
                        n_count     = r_count - CW'(1);
                        n_res_value = w_word[0];
                    end
                end
                ACT_PEEK: begin
                    if (peek_err) begin
                        n_res_value  = ERR_WORD;
                        n_res_status = STAT_PEEK;
                    end else begin
                        n_tgt        = down_w[IW-1:0];
                        n_scan       = down_w[IW-1:0];
                        n_from_chain = 1'b1;
                        n_state      = ST_SCAN;
                    end
                end
                ACT_BOTTOM: begin
                    if (empty) begin
                        n_res_value  = ERR_WORD;
                        n_res_status = STAT_EMPTY;
                    end else begin
                        n_tgt        = last_w[IW-1:0];
                        n_scan       = last_w[IW-1:0];
                        n_from_chain = 1'b1;
                        n_state      = ST_SCAN;
                    end
                end
                ACT_TOP: begin
                    if (empty) begin
                        n_res_value  = ERR_WORD;
                        n_res_status = STAT_EMPTY;
                    end else begin
                        n_res_value = w_word[0];
                    end
                end
                default: begin
                    // unused codes leave the stack as it is
                end
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_value  <= r_from_chain ? w_rd[0] : r_res_value;
            r_out_status <= r_res_status;
            r_out_count  <= count_w[COUNT_W-1:0];
        end
    end

    assign i_req.ready       = in_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_value  = r_out_value;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_count = r_out_count;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.push |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the stack by one");

    a_scan_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (!in_ready && !ctl.push && !ctl.pop))
        else $error("stack moved during chain read");

    a_scan_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_scan == '0) |=> (r_state == ST_DONE))
        else $error("chain read did not finish");
`endif

endmodule

`default_nettype wire

// ===== sv/lsp_cell.sv =====
`default_nettype none

module lsp_cell #(
    parameter int IDX = 0,
    parameter int IW  = 4
) (
    input  wire logic                               i_clk,
    input  wire lsp_pkg::t_cell_ctl                 i_ctl,
    input  wire logic signed [lsp_pkg::WORD_W-1:0]  i_word_above,
    input  wire logic signed [lsp_pkg::WORD_W-1:0]  i_word_below,
    input  wire logic [IW-1:0]                      i_tgt,
    input  wire logic signed [lsp_pkg::WORD_W-1:0]  i_rd_below,
    output logic signed [lsp_pkg::WORD_W-1:0]       o_word,
    output logic signed [lsp_pkg::WORD_W-1:0]       o_rd
);
    import lsp_pkg::*;

    logic signed [WORD_W-1:0] r_word;
    logic signed [WORD_W-1:0] r_rd;

    // push moves every entry one place down, pop one place up
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_word <= i_word_above;
        end else if (i_ctl.pop) begin
            r_word <= i_word_below;
        end
    end

    // read chain: the target cell injects its word, the others pass toward the top
    always_ff @(posedge i_clk) begin
        if (i_tgt == IW'(IDX)) begin
            r_rd <= r_word;
        end else begin
            r_rd <= i_rd_below;
        end
    end

    assign o_word = r_word;
    assign o_rd   = r_rd;

endmodule

`default_nettype wire
